>>> hw/rtl/cic_pkg.sv
// Package for the control input conditioner: codes, tables and helpers.
`default_nettype none
package cic_pkg;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SH_M1, ST_SH_R1, ST_SH_M2, ST_SH_R2, ST_SH_M3, ST_SH_R3,
		ST_FL_M, ST_FL_R,
		ST_LV,
		ST_BD_M, ST_BD_R, ST_SM_M, ST_SM_R, ST_BE,
		ST_MD_M1, ST_MD_R1, ST_MD_M2, ST_MD_R2, ST_ME,
		ST_NT_M1, ST_NT_R1, ST_NT_M2, ST_NT_R2,
		ST_PR
	} state_t;

	// Pot shaping laws
	typedef enum logic [1:0] {LAW_LIN, LAW_SQ, LAW_QU} law_t;

	// Rounding shift selection for the shared multiplier
	typedef enum logic [1:0] {SH_16, SH_FB, SH_FB1} shift_t;

	// Clamp tops and smoother coefficients of the bound parameters
	typedef enum logic [1:0] {TOP_999, TOP_995, TOP_TWO} top_t;
	typedef enum logic {COEF_20, COEF_100} coef_t;

	// Request types
	localparam logic [1:0] REQ_POT  = 2'd0;
	localparam logic [1:0] REQ_CV   = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_POT_SMOOTHING  = 2'd0;
	localparam logic [1:0] CFG_JUMP_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_NOTE_SLEW      = 2'd2;

	// Parameter ids
	localparam logic [4:0] PID_BIND0 = 5'd4;
	localparam logic [4:0] PID_MOD   = 5'd14;
	localparam logic [4:0] PID_NOTE  = 5'd15;
	localparam logic [4:0] PID_PRESS = 5'd16;

	localparam logic [4:0] LEVEL_LAST = 5'd3;
	localparam logic [4:0] BIND_LAST  = 5'd9;
	localparam logic [2:0] SLOT_NONE  = 3'd7;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [4:0] pot;
		logic [4:0] att;
		logic [3:0] cv;
		top_t       top;
		logic [2:0] slot;
		coef_t      coef;
	} bind_entry_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > SAT_MAX)
			return 32'sh7FFFFFFF;
		else if (v < SAT_MIN)
			return 32'sh80000000;
		else
			return 32'(v);
	endfunction

	function automatic law_t pot_law(input logic [4:0] idx);
		case (idx)
			5'd3, 5'd6, 5'd8, 5'd11, 5'd13, 5'd15, 5'd18,
			5'd20, 5'd22, 5'd24, 5'd26: return LAW_SQ;
			5'd16: return LAW_QU;
			default: return LAW_LIN;
		endcase
	endfunction

	function automatic logic [4:0] level_pot(input logic [1:0] k);
		case (k)
			2'd0: return 5'd0;
			2'd1: return 5'd1;
			2'd2: return 5'd4;
			default: return 5'd9;
		endcase
	endfunction

	function automatic bind_entry_t bind_entry(input logic [3:0] k);
		case (k)
			4'd0: return '{5'd2,  5'd3,  4'd3,  TOP_999, SLOT_NONE, COEF_20};
			4'd1: return '{5'd5,  5'd6,  4'd4,  TOP_999, 3'd0,      COEF_20};
			4'd2: return '{5'd7,  5'd8,  4'd5,  TOP_999, SLOT_NONE, COEF_20};
			4'd3: return '{5'd10, 5'd11, 4'd6,  TOP_999, 3'd1,      COEF_20};
			4'd4: return '{5'd12, 5'd13, 4'd7,  TOP_995, SLOT_NONE, COEF_20};
			4'd5: return '{5'd17, 5'd18, 4'd9,  TOP_999, 3'd2,      COEF_20};
			4'd6: return '{5'd19, 5'd20, 4'd11, TOP_999, SLOT_NONE, COEF_20};
			4'd7: return '{5'd21, 5'd22, 4'd8,  TOP_999, SLOT_NONE, COEF_20};
			4'd8: return '{5'd23, 5'd24, 4'd10, TOP_999, 3'd3,      COEF_100};
			default: return '{5'd25, 5'd26, 4'd12, TOP_TWO, 3'd4, COEF_100};
		endcase
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/control_input_conditioner.sv
// Control input conditioner: pot shaping, pot filtering and parameter sequencer.
// Cv and linear pot samples are written straight to their stores; squared and quartic pots use the multiplier.
// A tick emits 17 transfers in id order while it runs, and waits whenever the output stalls.
// The one shared multiplier serves every product, a multiply state then a round state: 46 products a tick.
// in_ready is high only while the sequencer is idle; an output register holds each result.
// Reset (arst_n low) clears all stores and state and loads the register defaults.
`default_nettype none
module control_input_conditioner #(
	parameter int POT_COUNT = 27,
	parameter int CV_COUNT  = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [19:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [4:0]         channel,
	input  wire logic signed [31:0] sample,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [4:0]              param_id,
	output logic signed [31:0]      param_value,
	output logic                    last
);

	localparam int PW = $clog2(POT_COUNT);
	localparam int CW = $clog2(CV_COUNT);

	localparam longint C_ONE    = longint'(1) << FRAC_BITS;
	localparam longint C_TOP999 = ((longint'(19990) << FRAC_BITS) + 10000) / 20000;
	localparam longint C_TOP995 = ((longint'(199) << FRAC_BITS) + 100) / 200;
	localparam longint C_TWO    = longint'(2) << FRAC_BITS;
	localparam longint C_K20    = ((longint'(1) << FRAC_BITS) + 10) / 20;
	localparam longint C_K100   = ((longint'(1) << FRAC_BITS) + 50) / 100;
	localparam longint C_33     = ((longint'(33) << FRAC_BITS) + 5) / 10;
	localparam longint C_495    = ((longint'(99) << FRAC_BITS) + 1) / 2;
	localparam longint C_2033   = ((longint'(20) << FRAC_BITS) + 16) / 33;
	localparam longint C_60     = longint'(60) << FRAC_BITS;
	localparam longint C_SQMAX  = longint'(1) << 31;
	localparam longint C_MDMAX  = longint'(1) << 32;
	localparam longint H_16     = longint'(1) << 15;
	localparam longint H_FB     = longint'(1) << (FRAC_BITS - 1);
	localparam longint H_FB1    = longint'(1) << FRAC_BITS;
	localparam logic [16:0] COEF_MAX = 17'd65536;

	// Stores
	logic signed [31:0] shaped_q [POT_COUNT];
	logic signed [31:0] filt_q [POT_COUNT];
	logic signed [31:0] cv_q [CV_COUNT];
	logic signed [31:0] smp_q [5];
	logic signed [31:0] sn_q, sm_q;
	logic [16:0] ps_q, ns_q;
	logic [19:0] jt_q;

	// Sequencer
	cic_pkg::state_t state_q, state_d;
	logic [4:0] idx_q, idx_d;
	logic [4:0] ch_q, ch_d;
	logic neg_q, neg_d;
	cic_pkg::law_t law_q, law_d;
	logic signed [63:0] acc_q, acc_d;
	logic signed [67:0] prod_q;

	// Output register
	logic out_valid_q;
	logic [4:0] out_id_q;
	logic signed [31:0] out_val_q;

	// Combinational controls
	logic mul_en;
	logic signed [33:0] mul_a, mul_b;
	cic_pkg::shift_t sh_sel;
	logic signed [63:0] p64, rnd;
	logic [PW-1:0] filt_addr, shaped_addr, shaped_waddr;
	logic [CW-1:0] cv_addr;
	logic [2:0] smp_addr;
	logic signed [31:0] filt_rd, shaped_rd, cv_rd, smp_rd;
	logic signed [63:0] filt64, shaped64, cv64, smp64, sn64, sm64, smp_top;
	logic filt_we, shaped_we, cv_we, smp_we, sn_we, sm_we;
	logic signed [31:0] filt_wd, shaped_wd, smp_wd, sn_d, sm_d;
	logic out_free, out_load;
	logic [4:0] out_id_d;
	logic signed [31:0] out_val_d;
	logic in_fire;
	logic [16:0] ps_c, ns_c;
	logic signed [63:0] thr, tmp, tmp2, ax;
	logic signed [31:0] m2;
	cic_pkg::bind_entry_t be;
	cic_pkg::law_t ch_law;

	assign in_ready    = (state_q == cic_pkg::ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign param_id    = out_id_q;
	assign param_value = out_val_q;
	assign last        = (out_id_q == cic_pkg::PID_PRESS);

	assign ps_c = (ps_q > COEF_MAX) ? COEF_MAX : ps_q;
	assign ns_c = (ns_q > COEF_MAX) ? COEF_MAX : ns_q;
	assign thr  = $signed(({44'd0, jt_q} << FRAC_BITS) >> 16);

	// Read ports of the stores
	assign filt_rd   = filt_q[filt_addr];
	assign shaped_rd = shaped_q[shaped_addr];
	assign cv_rd     = cv_q[cv_addr];
	assign smp_rd    = smp_q[smp_addr];
	assign filt64    = 64'(filt_rd);
	assign shaped64  = 64'(shaped_rd);
	assign cv64      = 64'(cv_rd);
	assign smp64     = 64'(smp_rd);
	assign sn64      = 64'(sn_q);
	assign sm64      = 64'(sm_q);
	assign be        = cic_pkg::bind_entry(idx_q[3:0]);
	assign ch_law    = cic_pkg::pot_law(channel);
	assign ax        = (sample < 0) ? -64'(sample) : 64'(sample);

	// Round the registered product
	assign p64 = prod_q[63:0];
	always_comb begin
		case (sh_sel)
			cic_pkg::SH_16:  rnd = (p64 + H_16) >>> 16;
			cic_pkg::SH_FB1: rnd = (p64 + H_FB1) >>> (FRAC_BITS + 1);
			default:         rnd = (p64 + H_FB) >>> FRAC_BITS;
		endcase
	end

	// Clamp top of the current bound parameter
	always_comb begin
		case (be.top)
			cic_pkg::TOP_995: smp_top = C_TOP995;
			cic_pkg::TOP_TWO: smp_top = C_TWO;
			default:          smp_top = C_TOP999;
		endcase
	end

	// Next state, operand selection and store writes
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		ch_d         = ch_q;
		neg_d        = neg_q;
		law_d        = law_q;
		acc_d        = acc_q;
		mul_en       = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		sh_sel       = cic_pkg::SH_FB;
		filt_addr    = idx_q[PW-1:0];
		shaped_addr  = idx_q[PW-1:0];
		shaped_waddr = channel[PW-1:0];
		cv_addr      = '0;
		smp_addr     = '0;
		filt_we      = 1'b0;
		filt_wd      = '0;
		shaped_we    = 1'b0;
		shaped_wd    = sample;
		cv_we        = 1'b0;
		smp_we       = 1'b0;
		smp_wd       = '0;
		sn_we        = 1'b0;
		sn_d         = '0;
		sm_we        = 1'b0;
		sm_d         = '0;
		out_load     = 1'b0;
		out_id_d     = '0;
		out_val_d    = '0;
		tmp          = '0;
		tmp2         = '0;
		m2           = '0;
		unique case (state_q)
			cic_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (req_type)
						cic_pkg::REQ_POT: begin
							if (6'(channel) < 6'(POT_COUNT)) begin
								if (ch_law == cic_pkg::LAW_LIN) begin
									shaped_we = 1'b1;
								end else begin
									ch_d    = channel;
									neg_d   = sample < 0;
									law_d   = ch_law;
									acc_d   = ax;
									state_d = cic_pkg::ST_SH_M1;
								end
							end
						end
						cic_pkg::REQ_CV: begin
							if (6'(channel) < 6'(CV_COUNT))
								cv_we = 1'b1;
						end
						cic_pkg::REQ_TICK: begin
							idx_d   = '0;
							state_d = cic_pkg::ST_FL_M;
						end
						default: ;
					endcase
				end
			end
			// Shaping: square, optional second square, then scale by 3.3
			cic_pkg::ST_SH_M1, cic_pkg::ST_SH_M2: begin
				mul_en  = 1'b1;
				mul_a   = 34'(acc_q);
				mul_b   = 34'(acc_q);
				state_d = (state_q == cic_pkg::ST_SH_M1) ? cic_pkg::ST_SH_R1 : cic_pkg::ST_SH_R2;
			end
			cic_pkg::ST_SH_R1, cic_pkg::ST_SH_R2: begin
				acc_d = (rnd < 0) ? 64'sd0 : ((rnd > C_SQMAX) ? C_SQMAX : rnd);
				if (state_q == cic_pkg::ST_SH_R1 && law_q == cic_pkg::LAW_QU)
					state_d = cic_pkg::ST_SH_M2;
				else
					state_d = cic_pkg::ST_SH_M3;
			end
			cic_pkg::ST_SH_M3: begin
				mul_en  = 1'b1;
				mul_a   = 34'(acc_q);
				mul_b   = 34'(C_33);
				state_d = cic_pkg::ST_SH_R3;
			end
			cic_pkg::ST_SH_R3: begin
				shaped_we    = 1'b1;
				shaped_waddr = ch_q[PW-1:0];
				shaped_wd    = cic_pkg::sat32(neg_q ? -rnd : rnd);
				state_d      = cic_pkg::ST_IDLE;
			end
			// Pot low-pass, one pot at a time in index order
			cic_pkg::ST_FL_M: begin
				mul_en  = 1'b1;
				mul_a   = 34'(shaped64 - filt64);
				mul_b   = $signed({17'd0, ps_c});
				sh_sel  = cic_pkg::SH_16;
				state_d = cic_pkg::ST_FL_R;
			end
			cic_pkg::ST_FL_R: begin
				sh_sel  = cic_pkg::SH_16;
				filt_we = 1'b1;
				filt_wd = cic_pkg::sat32(filt64 + rnd);
				if (idx_q == 5'(POT_COUNT - 1)) begin
					idx_d   = '0;
					state_d = cic_pkg::ST_LV;
				end else begin
					idx_d   = idx_q + 5'd1;
					state_d = cic_pkg::ST_FL_M;
				end
			end
			// Plain levels
			cic_pkg::ST_LV: begin
				filt_addr = PW'(cic_pkg::level_pot(idx_q[1:0]));
				if (out_free) begin
					out_load  = 1'b1;
					out_id_d  = idx_q;
					out_val_d = filt_rd;
					if (idx_q == cic_pkg::LEVEL_LAST) begin
						idx_d   = '0;
						state_d = cic_pkg::ST_BD_M;
					end else begin
						idx_d = idx_q + 5'd1;
					end
				end
			end
			// Pot plus attenuverter times cv
			cic_pkg::ST_BD_M: begin
				filt_addr = PW'(be.att);
				cv_addr   = CW'(be.cv);
				mul_en    = 1'b1;
				mul_a     = 34'(filt_rd);
				mul_b     = 34'(cv_rd);
				sh_sel    = cic_pkg::SH_FB1;
				state_d   = cic_pkg::ST_BD_R;
			end
			cic_pkg::ST_BD_R: begin
				filt_addr = PW'(be.pot);
				sh_sel    = cic_pkg::SH_FB1;
				tmp       = filt64 + rnd;
				acc_d     = (tmp < 0) ? 64'sd0 : ((tmp > smp_top) ? smp_top : tmp);
				state_d   = (be.slot == cic_pkg::SLOT_NONE) ? cic_pkg::ST_BE : cic_pkg::ST_SM_M;
			end
			cic_pkg::ST_SM_M: begin
				smp_addr = be.slot;
				mul_en   = 1'b1;
				mul_a    = 34'(acc_q - smp64);
				mul_b    = (be.coef == cic_pkg::COEF_100) ? 34'(C_K100) : 34'(C_K20);
				state_d  = cic_pkg::ST_SM_R;
			end
			cic_pkg::ST_SM_R: begin
				smp_addr = be.slot;
				smp_we   = 1'b1;
				smp_wd   = cic_pkg::sat32(smp64 + rnd);
				acc_d    = 64'(smp_wd);
				state_d  = cic_pkg::ST_BE;
			end
			cic_pkg::ST_BE: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_id_d  = cic_pkg::PID_BIND0 + idx_q;
					out_val_d = cic_pkg::sat32(acc_q);
					if (idx_q == cic_pkg::BIND_LAST) begin
						idx_d   = '0;
						state_d = cic_pkg::ST_MD_M1;
					end else begin
						idx_d   = idx_q + 5'd1;
						state_d = cic_pkg::ST_BD_M;
					end
				end
			end
			// FM modulation depth and its smoother
			cic_pkg::ST_MD_M1: begin
				filt_addr = PW'(16);
				cv_addr   = CW'(1);
				mul_en    = 1'b1;
				mul_a     = 34'(filt_rd);
				mul_b     = 34'(cv_rd);
				state_d   = cic_pkg::ST_MD_R1;
			end
			cic_pkg::ST_MD_R1: begin
				acc_d   = (rnd < -C_MDMAX) ? -C_MDMAX : ((rnd > C_MDMAX) ? C_MDMAX : rnd);
				state_d = cic_pkg::ST_MD_M2;
			end
			cic_pkg::ST_MD_M2: begin
				mul_en  = 1'b1;
				mul_a   = 34'(acc_q);
				mul_b   = 34'(C_495);
				state_d = cic_pkg::ST_MD_R2;
			end
			cic_pkg::ST_MD_R2: begin
				m2      = cic_pkg::sat32(rnd);
				tmp     = (64'(m2) - sm64 + 64'sd1) >>> 1;
				sm_we   = 1'b1;
				sm_d    = cic_pkg::sat32(sm64 + tmp);
				state_d = cic_pkg::ST_ME;
			end
			cic_pkg::ST_ME: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_id_d  = cic_pkg::PID_MOD;
					out_val_d = (sm64 < -C_60) ? 32'(-C_60) :
						((sm64 > C_60) ? 32'(C_60) : sm_q);
					state_d   = cic_pkg::ST_NT_M1;
				end
			end
			// Note slew with jump, then offsets
			cic_pkg::ST_NT_M1: begin
				mul_en  = 1'b1;
				mul_a   = 34'(cv64 - sn64);
				mul_b   = $signed({17'd0, ns_c});
				sh_sel  = cic_pkg::SH_16;
				state_d = cic_pkg::ST_NT_R1;
			end
			cic_pkg::ST_NT_R1: begin
				sh_sel = cic_pkg::SH_16;
				tmp    = cv64 - sn64;
				sn_we  = 1'b1;
				if (tmp < -thr || tmp > thr)
					sn_d = cv_rd;
				else
					sn_d = cic_pkg::sat32(sn64 + rnd);
				state_d = cic_pkg::ST_NT_M2;
			end
			cic_pkg::ST_NT_M2: begin
				filt_addr = PW'(15);
				mul_en    = 1'b1;
				mul_a     = 34'(filt_rd);
				mul_b     = 34'(C_2033);
				state_d   = cic_pkg::ST_NT_R2;
			end
			cic_pkg::ST_NT_R2: begin
				shaped_addr = PW'(14);
				tmp2        = sn64 + shaped64 + rnd;
				if (out_free) begin
					out_load  = 1'b1;
					out_id_d  = cic_pkg::PID_NOTE;
					out_val_d = cic_pkg::sat32(tmp2);
					state_d   = cic_pkg::ST_PR;
				end
			end
			// Pressure
			cic_pkg::ST_PR: begin
				cv_addr = CW'(2);
				if (out_free) begin
					out_load  = 1'b1;
					out_id_d  = cic_pkg::PID_PRESS;
					out_val_d = (cv64 < 0) ? 32'sd0 : ((cv64 > C_ONE) ? 32'(C_ONE) : cv_rd);
					state_d   = cic_pkg::ST_IDLE;
				end
			end
			default: state_d = cic_pkg::ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cic_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Working registers and shared multiplier
	always_ff @(posedge clk) begin
		ch_q  <= ch_d;
		neg_q <= neg_d;
		law_q <= law_d;
		acc_q <= acc_d;
		if (mul_en)
			prod_q <= mul_a * mul_b;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= 17'd655;
			jt_q <= 20'd26214;
			ns_q <= 17'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				cic_pkg::CFG_POT_SMOOTHING:  ps_q <= cfg_data[16:0];
				cic_pkg::CFG_JUMP_THRESHOLD: jt_q <= cfg_data;
				cic_pkg::CFG_NOTE_SLEW:      ns_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Stores, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POT_COUNT; i++) begin
				shaped_q[i] <= '0;
				filt_q[i]   <= '0;
			end
			for (int i = 0; i < CV_COUNT; i++)
				cv_q[i] <= '0;
			for (int i = 0; i < 5; i++)
				smp_q[i] <= '0;
			sn_q <= '0;
			sm_q <= '0;
		end else begin
			if (shaped_we)
				shaped_q[shaped_waddr] <= shaped_wd;
			if (filt_we)
				filt_q[filt_addr] <= filt_wd;
			if (cv_we)
				cv_q[channel[CW-1:0]] <= sample;
			if (smp_we)
				smp_q[smp_addr] <= smp_wd;
			if (sn_we)
				sn_q <= sn_d;
			if (sm_we)
				sm_q <= sm_d;
		end
	end

	// Output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_id_q  <= out_id_d;
			out_val_q <= out_val_d;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cic_checker.sv
// Port checker for the control input conditioner, with its bind.
`default_nettype none
module cic_port_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cfg_we,
	input wire logic [1:0]         cfg_index,
	input wire logic [19:0]        cfg_data,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [1:0]         req_type,
	input wire logic [4:0]         channel,
	input wire logic signed [31:0] sample,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [4:0]         param_id,
	input wire logic signed [31:0] param_value,
	input wire logic               last
);

	// Last flag marks exactly the pressure parameter
	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (param_id == cic_pkg::PID_PRESS)))
		else $error("last flag does not match pressure id");

	// Pressure stays in the unit range from below
	a_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && param_id == cic_pkg::PID_PRESS |-> param_value >= 0)
		else $error("pressure below zero");

	// A tick keeps the input side busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == cic_pkg::REQ_TICK |=> !in_ready)
		else $error("input ready right after tick transfer");

	// Ids never exceed the last parameter
	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> param_id <= cic_pkg::PID_PRESS)
		else $error("parameter id out of range");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(param_id) && $stable(param_value))
		else $error("stalled result changed");

endmodule

bind control_input_conditioner cic_port_checker u_cic_checker (.*);
`default_nettype wire
